[hw/rtl/rtws_pkg.sv]
// shared constants, types and state codes for the run-time window statistics core
`default_nettype none
package rtws_pkg;

    localparam int WINDOW  = 1024;
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int COUNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W   = 32 + SLOT_W;
    localparam int STEP_W  = $clog2(SUM_W + 1);

    localparam logic [31:0] RESET_OVERFLOW_NS = 32'd33554430;
    localparam logic [7:0]  RESET_TICK_NS     = 8'd20;
    localparam logic [31:0] SAT32             = 32'hFFFF_FFFF;

    // register select taken from paddr[2]
    localparam logic REG_OVERFLOW_NS = 1'b0;
    localparam logic REG_TICK_NS     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_UPD,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

[hw/rtl/rtws_ring.sv]
// sample ring memory: one write port, one registered read port
`default_nettype none
module rtws_ring (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [rtws_pkg::SLOT_W-1:0] wr_addr,
    input  wire logic [31:0]               wr_data,
    input  wire logic                      rd_en,
    input  wire logic [rtws_pkg::SLOT_W-1:0] rd_addr,
    output logic      [31:0]               rd_data
);

    logic [31:0] mem [rtws_pkg::WINDOW];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[hw/rtl/rtws_duration.sv]
// two-stage run duration datapath: scaled products, then sum with saturation
`default_nettype none
module rtws_duration (
    input  wire logic        aclk,
    input  wire logic [7:0]  overflow_count,
    input  wire logic [23:0] tick_count,
    input  wire logic [31:0] overflow_ns,
    input  wire logic [7:0]  tick_ns,
    output logic      [31:0] sample_ns
);

    logic [39:0] period_prod_reg;
    logic [31:0] tick_prod_reg;
    logic [40:0] total;

    always_ff @(posedge aclk) begin
        period_prod_reg <= 40'(overflow_count) * 40'(overflow_ns);
        tick_prod_reg   <= 32'(tick_count) * 32'(tick_ns);
    end

    assign total = 41'(period_prod_reg) + 41'(tick_prod_reg);

    always_ff @(posedge aclk) begin
        if (total[40:32] != 9'd0) begin
            sample_ns <= rtws_pkg::SAT32;
        end else begin
            sample_ns <= total[31:0];
        end
    end

endmodule
`default_nettype wire

[hw/rtl/rtws_div.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none
module rtws_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [rtws_pkg::SUM_W-1:0]   dividend,
    input  wire logic [rtws_pkg::COUNT_W-1:0] divisor,
    output logic      [31:0]                  quotient,
    output logic                              done
);

    localparam int SW = rtws_pkg::SUM_W;
    localparam int CW = rtws_pkg::COUNT_W;

    logic [SW-1:0]                 quo_reg;
    logic [CW-1:0]                 rem_reg;
    logic [CW-1:0]                 dvs_reg;
    logic [rtws_pkg::STEP_W-1:0]   step_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [CW:0]                   rem_shift;
    logic                          fits;

    assign rem_shift = {rem_reg, quo_reg[SW-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= rtws_pkg::STEP_W'(SW);
            end else if (busy_reg) begin
                step_reg <= step_reg - rtws_pkg::STEP_W'(1);
                if (step_reg == rtws_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so it fits in CW bits
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[SW-2:0], fits};
            rem_reg <= fits ? CW'(rem_shift - {1'b0, dvs_reg}) : rem_shift[CW-1:0];
        end
    end

    assign quotient = quo_reg[31:0];
    assign done     = done_reg;

endmodule
`default_nettype wire

[hw/rtl/run_time_window_statistics_core.sv]
// top level: sequencer, window state, config registers and output word register
`default_nettype none
// Converts each run word (overflow count, tick count) to nanoseconds, saturated at
// 2^32-1, stores it in a ring of WINDOW samples held in an on-chip RAM, and returns
// the sample, the truncated average of the stored samples, and the longest and
// shortest samples since reset. One word is processed at a time: the next word is
// taken only after the result of the current one has been loaded. Each word goes
// through the duration multiply and add (the ring read of the oldest sample overlaps
// the multiply), the sum update and ring write, the bit-serial divider that forms the
// average over SUM_W dividend bits, a state that sees the divider finish, and the
// load of the output register. The result sits in an output register, so a new word
// is accepted while the previous result waits; the next finished word then holds
// until that result leaves. No clearing pass is needed after reset: ring entries are
// used only after the whole ring has been written once.
module run_time_window_statistics_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_overflow_count,
    input  wire logic [23:0] s_tick_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_sample_ns,
    output logic      [31:0] m_average_ns,
    output logic      [31:0] m_longest_ns,
    output logic      [31:0] m_shortest_ns,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int SW = rtws_pkg::SUM_W;
    localparam int CW = rtws_pkg::COUNT_W;
    localparam int LW = rtws_pkg::SLOT_W;

    rtws_pkg::state_t state_reg, state_next;

    logic [31:0]   overflow_ns_reg;
    logic [7:0]    tick_ns_reg;
    logic [7:0]    ovf_cnt_reg;
    logic [23:0]   tick_cnt_reg;
    logic [LW-1:0] write_slot_reg;
    logic          window_full_reg;
    logic [SW-1:0] window_sum_reg;
    logic [31:0]   longest_reg;
    logic [31:0]   shortest_reg;
    logic          m_valid_reg;
    logic [31:0]   m_sample_reg;
    logic [31:0]   m_average_reg;
    logic [31:0]   m_longest_reg;
    logic [31:0]   m_shortest_reg;

    logic [31:0]   sample;
    logic [31:0]   oldest;
    logic [SW-1:0] sum_next;
    logic [LW-1:0] slot_next;
    logic          full_next;
    logic [CW-1:0] count_next;
    logic          wrap;
    logic          ring_rd_en;
    logic          ring_wr_en;
    logic          div_start;
    logic          load_out;
    logic          cfg_wr;
    logic [31:0]   quotient;
    logic          div_done;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overflow_ns_reg <= rtws_pkg::RESET_OVERFLOW_NS;
            tick_ns_reg     <= rtws_pkg::RESET_TICK_NS;
        end else if (cfg_wr) begin
            case (paddr[2])
                rtws_pkg::REG_OVERFLOW_NS: overflow_ns_reg <= pwdata;
                rtws_pkg::REG_TICK_NS:     tick_ns_reg     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rtws_pkg::REG_OVERFLOW_NS: prdata = overflow_ns_reg;
            rtws_pkg::REG_TICK_NS:     prdata = {24'd0, tick_ns_reg};
            default:                   prdata = '0;
        endcase
    end

    rtws_duration u_duration (
        .aclk           (aclk),
        .overflow_count (ovf_cnt_reg),
        .tick_count     (tick_cnt_reg),
        .overflow_ns    (overflow_ns_reg),
        .tick_ns        (tick_ns_reg),
        .sample_ns      (sample)
    );

    rtws_ring u_ring (
        .aclk    (aclk),
        .wr_en   (ring_wr_en),
        .wr_addr (write_slot_reg),
        .wr_data (sample),
        .rd_en   (ring_rd_en),
        .rd_addr (write_slot_reg),
        .rd_data (oldest)
    );

    // window bookkeeping for the word being finished
    assign wrap       = write_slot_reg == LW'(rtws_pkg::WINDOW - 1);
    assign slot_next  = wrap ? '0 : write_slot_reg + LW'(1);
    assign full_next  = window_full_reg | wrap;
    assign count_next = full_next ? CW'(rtws_pkg::WINDOW) : CW'(slot_next);
    assign sum_next   = window_sum_reg - (window_full_reg ? SW'(oldest) : '0) + SW'(sample);

    rtws_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (count_next),
        .quotient (quotient),
        .done     (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rtws_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        ring_rd_en = 1'b0;
        ring_wr_en = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            rtws_pkg::ST_IDLE: begin
                // no word is taken while reset is held
                s_ready = aresetn;
                if (s_valid) begin
                    state_next = rtws_pkg::ST_MUL;
                end
            end
            rtws_pkg::ST_MUL: begin
                ring_rd_en = 1'b1;
                state_next = rtws_pkg::ST_ADD;
            end
            rtws_pkg::ST_ADD: begin
                state_next = rtws_pkg::ST_UPD;
            end
            rtws_pkg::ST_UPD: begin
                ring_wr_en = 1'b1;
                div_start  = 1'b1;
                state_next = rtws_pkg::ST_DIV;
            end
            rtws_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = rtws_pkg::ST_OUT;
                end
            end
            rtws_pkg::ST_OUT: begin
                // wait for the previous result word to leave
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = rtws_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rtws_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ovf_cnt_reg  <= s_overflow_count;
            tick_cnt_reg <= s_tick_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_slot_reg  <= '0;
            window_full_reg <= 1'b0;
            window_sum_reg  <= '0;
            longest_reg     <= '0;
            shortest_reg    <= rtws_pkg::SAT32;
        end else if (ring_wr_en) begin
            write_slot_reg  <= slot_next;
            window_full_reg <= full_next;
            window_sum_reg  <= sum_next;
            if (sample > longest_reg) begin
                longest_reg <= sample;
            end
            if (sample < shortest_reg) begin
                shortest_reg <= sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_sample_reg   <= sample;
            m_average_reg  <= quotient;
            m_longest_reg  <= longest_reg;
            m_shortest_reg <= shortest_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sample_ns   = m_sample_reg;
    assign m_average_ns  = m_average_reg;
    assign m_longest_ns  = m_longest_reg;
    assign m_shortest_ns = m_shortest_reg;

endmodule
`default_nettype wire
